@@ rtl/sia_pkg.sv @@
// Shared types and constants for the slot index allocator.
`timescale 1ns / 1ps

package sia_pkg;

   localparam int unsigned SLOTS_DEF = 1024;

   localparam int SLOT_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_RESERVE = 2'd2,
      CMD_QUERY   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_LIVE  = 2'd2,
      STAT_SATURATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_EXEC = 2'd1,
      FSM_FILL = 2'd2
   } fsm_type;

   typedef struct packed {
      logic live;
      logic kind;
   } slot_entry_type;

endpackage

@@ rtl/sia_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module sia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/slot_id_allocator.sv @@
// Top level of the slot index allocator: sequencer, counters and the two state RAMs.
`timescale 1ns / 1ps

// Hands out slot indices from a circular free deque, falling back to a high-water
// mark when the deque is empty. One request beat produces exactly one response
// beat. For allocate, release, query and a reserve of zero, the beat's RAM read
// is issued in the cycle it is accepted and the read-modify-write and response
// follow in the EXEC state. A reserve that adds n indices first pushes them in the
// FILL state, one index per cycle, through the single write port of each RAM.
// A stalled response holds the sequencer in its final cycle; the next request
// beat is taken once the response register is loaded, even while it still waits.
// Both RAMs come up uninitialized and need no clearing pass: every slot below the
// high-water mark is written before it can be read.
module slot_id_allocator #(
   parameter int unsigned SLOTS = sia_pkg::SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] slot, [20:10] reserve_count, [21] kind, [23:22] zero
   input  logic [sia_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] command
   input  logic [sia_pkg::CMD_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [9:0] granted_slot, [10] slot_kind, [21:11] live_total, [32:22] free_total,
   // [39:33] zero
   output logic [sia_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [sia_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int XW = (sia_pkg::SLOT_W > CW) ? sia_pkg::SLOT_W : CW;
   localparam int NW = (sia_pkg::COUNT_W > CW) ? sia_pkg::COUNT_W : CW;
   localparam int SW = CW + 1;
   localparam int PAD_W = sia_pkg::RSP_DATA_W - sia_pkg::SLOT_W - 1 - 2 * sia_pkg::COUNT_W;
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
   localparam logic [SW-1:0] SLOTS_S = SW'(SLOTS);

   function automatic logic [IW-1:0] wrap_pos(input logic [SW-1:0] p);
      logic [SW-1:0] w;
      w = (p >= SLOTS_S) ? (p - SLOTS_S) : p;
      return w[IW-1:0];
   endfunction

   // Control and counters
   sia_pkg::fsm_type  state_ff, state_in;
   sia_pkg::cmd_type  cmd_ff, cmd_in;
   logic [sia_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic              kind_ff, kind_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     add_ff, add_in;
   logic              sat_ff, sat_in;
   logic [IW-1:0]     head_ff, head_in;
   logic [CW-1:0]     fc_ff, fc_in;
   logic [CW-1:0]     hw_ff, hw_in;
   logic [CW-1:0]     live_ff, live_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [sia_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [sia_pkg::COUNT_W-1:0] rsp_live_ff, rsp_live_in;
   logic [sia_pkg::COUNT_W-1:0] rsp_free_ff, rsp_free_in;
   sia_pkg::status_type rsp_status_ff, rsp_status_in;

   // Request fields
   logic [sia_pkg::SLOT_W-1:0]  in_slot;
   logic [sia_pkg::COUNT_W-1:0] in_count;
   logic                        in_kind;
   sia_pkg::cmd_type            in_cmd;
   logic                        accept;
   logic                        out_free;

   // Reserve clamp
   logic [CW-1:0] room;
   logic [NW-1:0] count_x;
   logic [NW-1:0] room_x;
   logic [CW-1:0] rsv_n;
   logic          rsv_sat;

   // RAM ports
   logic          smem_we, smem_re;
   logic [IW-1:0] smem_waddr, smem_raddr;
   sia_pkg::slot_entry_type smem_wdata, smem_rdata;
   logic          dmem_we, dmem_re;
   logic [IW-1:0] dmem_waddr, dmem_raddr, dmem_rdata, dmem_wdata;

   // Datapath helpers
   logic [XW-1:0] slot_x;
   logic [IW-1:0] slot_addr;
   logic          hit;
   logic [IW-1:0] idx;
   logic [XW-1:0] idx_x;
   logic [IW-1:0] head_dec;
   logic [CW-1:0] fill_val;
   logic [NW-1:0] live_x;
   logic [NW-1:0] fc_x;

   assign in_slot  = req_tdata[sia_pkg::SLOT_W-1:0];
   assign in_count = req_tdata[sia_pkg::SLOT_W +: sia_pkg::COUNT_W];
   assign in_kind  = req_tdata[sia_pkg::SLOT_W + sia_pkg::COUNT_W];
   assign in_cmd   = sia_pkg::cmd_type'(req_tuser);

   assign req_tready = (state_ff == sia_pkg::FSM_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign room    = SLOTS_C - hw_ff;
   assign count_x = NW'(in_count);
   assign room_x  = NW'(room);
   assign rsv_sat = (count_x > room_x);
   assign rsv_n   = rsv_sat ? room : count_x[CW-1:0];

   assign slot_x    = XW'(slot_ff);
   assign slot_addr = slot_x[IW-1:0];
   assign hit       = (slot_x < XW'(hw_ff)) && (slot_x < XW'(SLOTS)) && smem_rdata.live;
   assign head_dec  = (head_ff == '0) ? IW'(SLOTS - 1) : (head_ff - 1'b1);
   assign fill_val  = hw_ff + rem_ff - 1'b1;

   // Reads are issued with the accepted beat: slot RAM from the request slot field, deque RAM at its back entry
   always_comb begin
      logic [XW-1:0] in_slot_x;
      in_slot_x  = XW'(in_slot);
      smem_re    = accept;
      smem_raddr = in_slot_x[IW-1:0];
      dmem_re    = accept;
      dmem_raddr = wrap_pos(SW'(head_ff) + SW'(fc_ff) - 1'b1);
   end

   sia_ram #(
      .WIDTH ($bits(sia_pkg::slot_entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (smem_we),
      .wr_addr (smem_waddr),
      .wr_data (smem_wdata),
      .rd_en   (smem_re),
      .rd_addr (smem_raddr),
      .rd_data (smem_rdata)
   );

   sia_ram #(
      .WIDTH (IW),
      .DEPTH (SLOTS)
   ) u_deque_ram (
      .clock   (clock),
      .wr_en   (dmem_we),
      .wr_addr (dmem_waddr),
      .wr_data (dmem_wdata),
      .rd_en   (dmem_re),
      .rd_addr (dmem_raddr),
      .rd_data (dmem_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sia_pkg::FSM_IDLE: begin
            if (accept) begin
               if (in_cmd == sia_pkg::CMD_RESERVE && rsv_n != '0) begin
                  state_in = sia_pkg::FSM_FILL;
               end else begin
                  state_in = sia_pkg::FSM_EXEC;
               end
            end
         end
         sia_pkg::FSM_FILL: begin
            if (rem_ff == CW'(1)) begin
               state_in = sia_pkg::FSM_EXEC;
            end
         end
         sia_pkg::FSM_EXEC: begin
            if (out_free) begin
               state_in = sia_pkg::FSM_IDLE;
            end
         end
         default: state_in = sia_pkg::FSM_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cmd_in   = cmd_ff;
      slot_in  = slot_ff;
      kind_in  = kind_ff;
      rem_in   = rem_ff;
      add_in   = add_ff;
      sat_in   = sat_ff;
      head_in  = head_ff;
      fc_in    = fc_ff;
      hw_in    = hw_ff;
      live_in  = live_ff;

      smem_we    = 1'b0;
      smem_waddr = slot_addr;
      smem_wdata = '{live: 1'b0, kind: 1'b0};
      dmem_we    = 1'b0;
      dmem_waddr = head_dec;
      dmem_wdata = slot_addr;

      idx   = dmem_rdata;
      idx_x = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_free_in   = rsp_free_ff;

      unique case (state_ff)
         sia_pkg::FSM_IDLE: begin
            if (accept) begin
               cmd_in  = in_cmd;
               slot_in = in_slot;
               kind_in = in_kind;
               rem_in  = rsv_n;
               add_in  = rsv_n;
               sat_in  = rsv_sat;
            end
         end
         sia_pkg::FSM_FILL: begin
            // push hw + rem - 1 at the back, highest first
            smem_we    = 1'b1;
            smem_waddr = fill_val[IW-1:0];
            dmem_we    = 1'b1;
            dmem_waddr = wrap_pos(SW'(head_ff) + SW'(fc_ff));
            dmem_wdata = fill_val[IW-1:0];
            fc_in      = fc_ff + 1'b1;
            rem_in     = rem_ff - 1'b1;
         end
         sia_pkg::FSM_EXEC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = slot_ff;
               rsp_kind_in   = 1'b0;
               rsp_status_in = sia_pkg::STAT_OK;
               case (cmd_ff)
                  sia_pkg::CMD_ALLOC: begin
                     if (fc_ff != '0 || hw_ff < SLOTS_C) begin
                        if (fc_ff != '0) begin
                           idx   = dmem_rdata;
                           fc_in = fc_ff - 1'b1;
                        end else begin
                           idx   = hw_ff[IW-1:0];
                           hw_in = hw_ff + 1'b1;
                        end
                        smem_we     = 1'b1;
                        smem_waddr  = idx;
                        smem_wdata  = '{live: 1'b1, kind: kind_ff};
                        live_in     = live_ff + 1'b1;
                        idx_x       = XW'(idx);
                        rsp_slot_in = idx_x[sia_pkg::SLOT_W-1:0];
                        rsp_kind_in = kind_ff;
                     end else begin
                        rsp_slot_in   = '0;
                        rsp_status_in = sia_pkg::STAT_FULL;
                     end
                  end
                  sia_pkg::CMD_RELEASE: begin
                     if (hit) begin
                        smem_we    = 1'b1;
                        smem_waddr = slot_addr;
                        dmem_we    = 1'b1;
                        dmem_waddr = head_dec;
                        dmem_wdata = slot_addr;
                        head_in    = head_dec;
                        fc_in      = fc_ff + 1'b1;
                        live_in    = live_ff - 1'b1;
                     end else begin
                        rsp_status_in = sia_pkg::STAT_NOT_LIVE;
                     end
                  end
                  sia_pkg::CMD_RESERVE: begin
                     hw_in = hw_ff + add_ff;
                     if (sat_ff) begin
                        rsp_status_in = sia_pkg::STAT_SATURATED;
                     end
                  end
                  default: begin
                     if (hit) begin
                        rsp_kind_in = smem_rdata.kind;
                     end else begin
                        rsp_status_in = sia_pkg::STAT_NOT_LIVE;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase

      live_x      = NW'(live_in);
      fc_x        = NW'(fc_in);
      rsp_live_in = (state_ff == sia_pkg::FSM_EXEC && out_free) ?
                    live_x[sia_pkg::COUNT_W-1:0] : rsp_live_in;
      rsp_free_in = (state_ff == sia_pkg::FSM_EXEC && out_free) ?
                    fc_x[sia_pkg::COUNT_W-1:0] : rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sia_pkg::FSM_IDLE;
         head_ff      <= '0;
         fc_ff        <= '0;
         hw_ff        <= '0;
         live_ff      <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fc_ff        <= fc_in;
         hw_ff        <= hw_in;
         live_ff      <= live_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      kind_ff       <= kind_in;
      add_ff        <= add_in;
      sat_ff        <= sat_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_free_ff, rsp_live_ff, rsp_kind_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ verif/slot_id_checker.sv @@
// Response checker for the slot index allocator: tracks allocator state and compares beats.
`timescale 1ns / 1ps

module slot_id_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // [9:0] slot, [20:10] reserve_count, [21] kind, [23:22] zero
   input  logic [sia_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [sia_pkg::CMD_W-1:0]      req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [9:0] granted_slot, [10] slot_kind, [21:11] live_total, [32:22] free_total
   input  logic [sia_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   input  logic [sia_pkg::STATUS_W-1:0]   rsp_tuser,
   output int                             mismatches,
   output int                             outstanding
);

   import sia_pkg::*;

   localparam int SLOTS = SLOTS_DEF;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot_idx;
      status_type         status;
      logic               kind;
      logic [COUNT_W-1:0] live;
      logic [COUNT_W-1:0] free;
   } outcome_type;

   logic              live_map  [SLOTS];
   logic              kind_map  [SLOTS];
   logic [SLOT_W-1:0] free_ring [SLOTS];
   int                ring_head;
   int                ring_fill;
   int                water_mark;
   int                live_num;

   outcome_type       pending_outcomes [$];

   // Apply one command to the tracked allocator state and return its response.
   function automatic outcome_type apply_command(input cmd_type            cmd,
                                                 input logic [SLOT_W-1:0]  slot,
                                                 input logic [COUNT_W-1:0] count,
                                                 input logic               kind);
      outcome_type res;
      int       idx;
      int       room;
      int       n;
      int       i;
      bit       granted;
      res.slot_idx = slot;
      res.status   = STAT_OK;
      res.kind     = 1'b0;
      granted      = 1'b0;
      idx          = 0;
      case (cmd)
         CMD_ALLOC: begin
            // take from the back of the ring first, then from the high-water mark
            if (ring_fill > 0) begin
               idx = free_ring[(ring_head + ring_fill - 1) % SLOTS];
               ring_fill--;
               granted = 1'b1;
            end else if (water_mark < SLOTS) begin
               idx = water_mark;
               water_mark++;
               granted = 1'b1;
            end
            if (granted) begin
               if (!live_map[idx]) live_num++;
               live_map[idx] = 1'b1;
               kind_map[idx] = kind;
               res.slot_idx  = idx[SLOT_W-1:0];
               res.kind      = kind;
            end else begin
               res.slot_idx = '0;
               res.status   = STAT_FULL;
            end
         end
         CMD_RELEASE: begin
            if (int'(slot) < water_mark && live_map[slot]) begin
               live_map[slot] = 1'b0;
               kind_map[slot] = 1'b0;
               if (ring_fill < SLOTS) begin
                  ring_head            = (ring_head + SLOTS - 1) % SLOTS;
                  free_ring[ring_head] = slot;
                  ring_fill++;
               end
               if (live_num > 0) live_num--;
            end else begin
               res.status = STAT_NOT_LIVE;
            end
         end
         CMD_RESERVE: begin
            room = SLOTS - water_mark;
            n    = int'(count);
            if (n > room) begin
               n          = room;
               res.status = STAT_SATURATED;
            end
            // push highest first so the lowest new index sits at the back
            for (i = n; i > 0; i--) begin
               if (ring_fill < SLOTS) begin
                  free_ring[(ring_head + ring_fill) % SLOTS] = SLOT_W'(water_mark + i - 1);
                  ring_fill++;
               end
            end
            water_mark += n;
         end
         default: begin
            if (int'(slot) < water_mark && live_map[slot]) begin
               res.kind = kind_map[slot];
            end else begin
               res.status = STAT_NOT_LIVE;
            end
         end
      endcase
      res.live = COUNT_W'(live_num);
      res.free = COUNT_W'(ring_fill);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type seen;
      outcome_type want;
      outcome_type fresh;
      int       k;
      if (reset) begin
         for (k = 0; k < SLOTS; k++) begin
            live_map[k]  = 1'b0;
            kind_map[k]  = 1'b0;
            free_ring[k] = '0;
         end
         ring_head  = 0;
         ring_fill  = 0;
         water_mark = 0;
         live_num   = 0;
         pending_outcomes.delete();
         mismatches  = 0;
         outstanding = 0;
      end else begin
         // compare first: a response never belongs to a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            seen.slot_idx = rsp_tdata[9:0];
            seen.kind     = rsp_tdata[10];
            seen.live     = rsp_tdata[21:11];
            seen.free     = rsp_tdata[32:22];
            seen.status   = status_type'(rsp_tuser);
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response beat with none expected: slot %0d status %0d",
                           $realtime, seen.slot_idx, seen.status);
            end else begin
               want = pending_outcomes.pop_front();
               if (seen != want) begin
                  mismatches++;
                  // fields in order: slot/status/kind/live/free
                  if (mismatches <= 10)
                     $display("%0t: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                              $realtime,
                              want.slot_idx, want.status, want.kind, want.live, want.free,
                              seen.slot_idx, seen.status, seen.kind, seen.live, seen.free);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fresh = apply_command(cmd_type'(req_tuser), req_tdata[9:0],
                                  req_tdata[20:10], req_tdata[21]);
            pending_outcomes.insert(pending_outcomes.size(), fresh);
         end
         outstanding = pending_outcomes.size();
      end
   end

endmodule

@@ verif/tb_slot_id_allocator.sv @@
// Testbench top for the slot index allocator: clock, reset, request and response traffic.
`timescale 1ns / 1ps

module tb_slot_id_allocator;

   import sia_pkg::*;

   typedef enum int {
      MIX_BALANCED,
      MIX_FILL,
      MIX_DRAIN
   } mix_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [9:0] slot, [20:10] reserve_count, [21] kind, [23:22] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // [1:0] command
   logic [CMD_W-1:0]      req_tuser  = CMD_ALLOC;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [9:0] granted_slot, [10] slot_kind, [21:11] live_total, [32:22] free_total
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [1:0] status
   logic [STATUS_W-1:0]   rsp_tuser;

   int mismatches;
   int outstanding;
   int beats_sent   = 0;
   int quiet_beats  = 0;
   int quiet_cycles = 0;
   int grant_span   = 0;

   always #5 clock = ~clock;

   slot_id_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   slot_id_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_beat(input cmd_type            cmd,
                            input logic [SLOT_W-1:0]  slot,
                            input logic [COUNT_W-1:0] count,
                            input logic               kind);
      int gap;
      if (quiet_beats > 0) begin
         gap = 0;
         quiet_beats--;
      end else begin
         gap = idle_gap();
         if ($urandom_range(0, 99) < 2) quiet_beats = $urandom_range(20, 80);
      end
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, kind, count, slot};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_random(input mix_type mix);
      int                 roll;
      cmd_type            cmd;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
      roll  = $urandom_range(0, 99);
      slot  = SLOT_W'($urandom_range(0, grant_span));
      count = COUNT_W'($urandom_range(0, 1024));
      case (mix)
         MIX_BALANCED: begin
            if (roll < 40)      cmd = CMD_ALLOC;
            else if (roll < 65) cmd = CMD_RELEASE;
            else if (roll < 75) cmd = CMD_RESERVE;
            else                cmd = CMD_QUERY;
            if (cmd == CMD_RESERVE) count = COUNT_W'($urandom_range(0, 12));
         end
         MIX_FILL: begin
            if (roll < 98)      cmd = CMD_ALLOC;
            else if (roll < 99) cmd = CMD_QUERY;
            else                cmd = CMD_RESERVE;
            if (cmd == CMD_RESERVE) count = COUNT_W'($urandom_range(0, 40));
         end
         default: begin
            if (roll < 20)      cmd = CMD_ALLOC;
            else if (roll < 75) cmd = CMD_RELEASE;
            else if (roll < 80) cmd = CMD_RESERVE;
            else                cmd = CMD_QUERY;
         end
      endcase
      // widen the slot range for release and query as indices get handed out
      if (cmd == CMD_ALLOC)   grant_span += 1;
      if (cmd == CMD_RESERVE) grant_span += int'(count);
      if (grant_span > 1023)  grant_span = 1023;
      send_beat(cmd, slot, count, 1'($urandom_range(0, 1)));
   endtask

   // Response side: random back-pressure plus one long hold-off to fill the block.
   initial begin : drain
      int gap;
      bit held;
      gap  = 0;
      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (!held && beats_sent >= 600) begin
            held = 1'b1;
            gap  = 400;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            gap--;
         end else if (quiet_cycles > 0) begin
            rsp_tready <= 1'b1;
            quiet_cycles--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < 2) quiet_cycles = $urandom_range(40, 150);
            else gap = idle_gap();
         end
      end
   end

   initial begin : stimulus
      int i;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty allocator, then high-water grants
      send_beat(CMD_QUERY,   10'd0,    11'd0,    1'b0);
      send_beat(CMD_RELEASE, 10'd1023, 11'd1024, 1'b1);
      send_beat(CMD_ALLOC,   10'd0,    11'd0,    1'b1);
      send_beat(CMD_ALLOC,   10'd1023, 11'd1024, 1'b0);
      send_beat(CMD_QUERY,   10'd0,    11'd0,    1'b0);
      send_beat(CMD_QUERY,   10'd1,    11'd0,    1'b1);
      // release, double release, query of a freed slot
      send_beat(CMD_RELEASE, 10'd0,    11'd0,    1'b0);
      send_beat(CMD_RELEASE, 10'd0,    11'd0,    1'b1);
      send_beat(CMD_QUERY,   10'd0,    11'd0,    1'b0);
      // zero reserve changes nothing, then push three new indices at the back
      send_beat(CMD_RESERVE, 10'd0,    11'd0,    1'b1);
      send_beat(CMD_RESERVE, 10'd1023, 11'd3,    1'b0);
      for (i = 0; i < 5; i++)
         send_beat(CMD_ALLOC, SLOT_W'(i), 11'd0, 1'($urandom_range(0, 1)));
      send_beat(CMD_RELEASE, 10'd3,    11'd0,    1'b0);
      send_beat(CMD_RELEASE, 10'd5,    11'd0,    1'b1);
      send_beat(CMD_ALLOC,   10'd0,    11'd0,    1'b1);
      send_beat(CMD_QUERY,   10'd3,    11'd0,    1'b0);
      send_beat(CMD_QUERY,   10'd700,  11'd0,    1'b1);
      send_beat(CMD_QUERY,   10'd1023, 11'd1024, 1'b1);
      grant_span = 8;

      for (i = 0; i < 20; i++) send_random(MIX_BALANCED);
      // allocation-heavy run: exhaust the high-water mark and hit full
      for (i = 0; i < 1060; i++) send_random(MIX_FILL);
      send_beat(CMD_RESERVE, 10'd0, 11'd1024, 1'b1);
      for (i = 0; i < 20; i++) send_random(MIX_DRAIN);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("slot_id_allocator: match");
      end else begin
         $display("slot_id_allocator: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("slot_id_allocator: mismatch");
      $finish;
   end

endmodule

@@ slot_id_allocator.f @@
rtl/sia_pkg.sv
rtl/sia_ram.sv
rtl/slot_id_allocator.sv
verif/slot_id_checker.sv
verif/tb_slot_id_allocator.sv
